// ----- sv/cau_pkg.sv -----
// Shared types and constants for the complex arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;

   localparam int DW = 32;         // data width, two's complement
   localparam int FW = 16;         // fraction bits
   localparam int PW = 2 * DW;     // full product width
   localparam int WX = 2 * DW + 2; // signed width of exact sums
   localparam int NW = 2 * DW + 1; // magnitude of a divide numerator
   localparam int RW = 2 * DW + 1; // divider partial remainder

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MUL  = 4'd2,
      OP_DIV  = 4'd3,
      OP_NEG  = 4'd4,
      OP_PASS = 4'd5,
      OP_EQ   = 4'd6,
      OP_NE   = 4'd7,
      OP_INC  = 4'd8,
      OP_DEC  = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_DIVZ = 2'd2
   } status_type;

   // one divider lane: sign, overflow, partial remainder, dividend bits left, quotient
   typedef struct packed {
      logic          neg;
      logic          ovr;
      logic [RW-1:0] rem;
      logic [DW-1:0] num;
      logic [DW-1:0] quo;
   } part_type;

   typedef struct packed {
      logic signed [DW-1:0] re;
      logic signed [DW-1:0] im;
      logic                 cmp;
      status_type           status;
   } res_type;

   typedef struct packed {
      logic          valid;
      logic          is_div;
      logic          dz;
      logic [PW-1:0] den;
      part_type      p_re;
      part_type      p_im;
      res_type       res;
   } dv_type;

endpackage
`default_nettype wire

// ----- sv/complex_arithmetic_unit.sv -----
// Pipelined complex-number ALU in signed fixed point with a bit-per-stage divider.
//
//  channel | ports                                   | transfer
//  --------+-----------------------------------------+--------------------------
//  request | start, busy, req_op, req_a_*, req_b_*   | start high while busy low
//  result  | rsp_valid, rsp_res_*, rsp_compare_true, | rsp_valid high, one cycle
//          | rsp_status                              |
//
// One item per cycle; every op takes the same path through all stages, the divider
// included, which forms one quotient bit per pipeline stage.
// Synchronous reset clears the valid bits of all stages; data registers are not reset.
// busy stays low: the pipeline never stalls and the receiver cannot hold results off.
// Results leave in request order.
`timescale 1ns / 1ps
`default_nettype none
module complex_arithmetic_unit import cau_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [3:0]           req_op,
   input  wire logic signed [DW-1:0] req_a_re,
   input  wire logic signed [DW-1:0] req_a_im,
   input  wire logic signed [DW-1:0] req_b_re,
   input  wire logic signed [DW-1:0] req_b_im,
   output logic                      rsp_valid,
   output logic signed [DW-1:0]      rsp_res_re,
   output logic signed [DW-1:0]      rsp_res_im,
   output logic                      rsp_compare_true,
   output logic [1:0]                rsp_status
);

   localparam logic signed [WX-1:0] SAT_MAX = (WX)'({1'b0, {(DW-1){1'b1}}});
   localparam logic signed [WX-1:0] SAT_MIN = ~SAT_MAX;
   localparam logic signed [WX-1:0] ONE_V   = (WX)'(1) << FW;
   localparam logic [DW-1:0]        HALF_M1 = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0]        HALF_U  = {1'b1, {(DW-1){1'b0}}};

   // {overflow flag, clamped value}
   function automatic logic [DW:0] sat_fn(input logic signed [WX-1:0] v);
      if (v > SAT_MAX)
         return {1'b1, SAT_MAX[DW-1:0]};
      else if (v < SAT_MIN)
         return {1'b1, SAT_MIN[DW-1:0]};
      else
         return {1'b0, v[DW-1:0]};
   endfunction

   function automatic logic signed [WX-1:0] ext(input logic signed [DW-1:0] x);
      return (WX)'(x);
   endfunction

   function automatic logic signed [WX-1:0] ext2(input logic signed [PW-1:0] x);
      return (WX)'(x);
   endfunction

   function automatic part_type part_init(input logic signed [WX-1:0] n,
                                          input logic [PW-1:0] d);
      logic [WX-1:0] m;
      logic [NW-1:0] mag;
      part_type      p;
      m       = n[WX-1] ? -n : n;
      mag     = m[NW-1:0];
      p.neg   = n[WX-1];
      // quotient would need more than DW bits
      p.ovr   = (mag >> (DW - FW)) >= (NW)'(d);
      p.rem   = (RW)'(mag >> (DW - FW));
      p.num   = (DW)'(mag << FW);
      p.quo   = '0;
      return p;
   endfunction

   function automatic part_type part_step(input part_type p, input logic [PW-1:0] d);
      logic [RW-1:0] rs;
      logic          ge;
      part_type      o;
      rs    = {p.rem[RW-2:0], p.num[DW-1]};
      ge    = rs >= (RW)'(d);
      o     = p;
      o.rem = ge ? rs - (RW)'(d) : rs;
      o.quo = {p.quo[DW-2:0], ge};
      o.num = p.num << 1;
      return o;
   endfunction

   // {saturated, value}
   function automatic logic [DW:0] part_final(input part_type p);
      if (p.ovr || (!p.neg && p.quo > HALF_M1) || (p.neg && p.quo > HALF_U))
         return {1'b1, p.neg ? HALF_U : HALF_M1};
      else
         return {1'b0, p.neg ? -p.quo : p.quo};
   endfunction

   assign busy = 1'b0;

   // stage 1: operand capture
   logic                 s1_valid_ff;
   op_type               s1_op_ff;
   logic signed [DW-1:0] s1_a_re_ff, s1_a_im_ff, s1_b_re_ff, s1_b_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
      s1_op_ff   <= op_type'(req_op);
      s1_a_re_ff <= req_a_re;
      s1_a_im_ff <= req_a_im;
      s1_b_re_ff <= req_b_re;
      s1_b_im_ff <= req_b_im;
   end

   // stage 2: products, plus results of the simple ops
   logic signed [WX-1:0] sm_re, sm_im;
   logic                 sm_arith, sm_eq;
   logic [DW:0]          sm_sat_re, sm_sat_im;
   res_type              s2_res_in;

   always_comb begin
      sm_re    = '0;
      sm_im    = '0;
      sm_arith = 1'b1;
      sm_eq    = (s1_a_re_ff == s1_b_re_ff) && (s1_a_im_ff == s1_b_im_ff);
      s2_res_in.cmp = 1'b0;
      case (s1_op_ff) inside
         OP_ADD: begin
            sm_re = ext(s1_a_re_ff) + ext(s1_b_re_ff);
            sm_im = ext(s1_a_im_ff) + ext(s1_b_im_ff);
         end
         OP_SUB: begin
            sm_re = ext(s1_a_re_ff) - ext(s1_b_re_ff);
            sm_im = ext(s1_a_im_ff) - ext(s1_b_im_ff);
         end
         OP_NEG: begin
            sm_re = -ext(s1_a_re_ff);
            sm_im = -ext(s1_a_im_ff);
         end
         OP_PASS: begin
            sm_re = ext(s1_a_re_ff);
            sm_im = ext(s1_a_im_ff);
         end
         OP_EQ, OP_NE: begin
            sm_arith      = 1'b0;
            s2_res_in.cmp = (s1_op_ff == OP_EQ) == sm_eq;
         end
         OP_INC: begin
            sm_re = ext(s1_a_re_ff) + ONE_V;
            sm_im = ext(s1_a_im_ff) + ONE_V;
         end
         OP_DEC: begin
            sm_re = ext(s1_a_re_ff) - ONE_V;
            sm_im = ext(s1_a_im_ff) - ONE_V;
         end
         default: begin
            sm_arith = 1'b0;
         end
      endcase
      sm_sat_re        = sat_fn(sm_re);
      sm_sat_im        = sat_fn(sm_im);
      s2_res_in.re     = sm_sat_re[DW-1:0];
      s2_res_in.im     = sm_sat_im[DW-1:0];
      s2_res_in.status = (sm_arith && (sm_sat_re[DW] || sm_sat_im[DW])) ? ST_SAT : ST_OK;
   end

   logic                 s2_valid_ff;
   op_type               s2_op_ff;
   res_type              s2_res_ff;
   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bb_ff, p_cc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_op_ff  <= s1_op_ff;
      s2_res_ff <= s2_res_in;
      p_rr_ff   <= s1_a_re_ff * s1_b_re_ff;
      p_ii_ff   <= s1_a_im_ff * s1_b_im_ff;
      p_ri_ff   <= s1_a_re_ff * s1_b_im_ff;
      p_ir_ff   <= s1_a_im_ff * s1_b_re_ff;
      p_bb_ff   <= s1_b_re_ff * s1_b_re_ff;
      p_cc_ff   <= s1_b_im_ff * s1_b_im_ff;
   end

   // stage 3: multiply result, divide numerators and divisor
   logic signed [WX-1:0] mu_re, mu_im;
   logic [DW:0]          mu_sat_re, mu_sat_im;
   res_type              s3_res_in;

   always_comb begin
      // arithmetic shift floors toward negative infinity
      mu_re     = (ext2(p_rr_ff) - ext2(p_ii_ff)) >>> FW;
      mu_im     = (ext2(p_ri_ff) + ext2(p_ir_ff)) >>> FW;
      mu_sat_re = sat_fn(mu_re);
      mu_sat_im = sat_fn(mu_im);
      if (s2_op_ff == OP_MUL) begin
         s3_res_in.re     = mu_sat_re[DW-1:0];
         s3_res_in.im     = mu_sat_im[DW-1:0];
         s3_res_in.cmp    = 1'b0;
         s3_res_in.status = (mu_sat_re[DW] || mu_sat_im[DW]) ? ST_SAT : ST_OK;
      end else begin
         s3_res_in = s2_res_ff;
      end
   end

   logic                 s3_valid_ff, s3_is_div_ff;
   res_type              s3_res_ff;
   logic signed [WX-1:0] s3_nr_ff, s3_ni_ff;
   logic [PW-1:0]        s3_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_is_div_ff <= s2_op_ff == OP_DIV;
      s3_res_ff    <= s3_res_in;
      s3_nr_ff     <= ext2(p_rr_ff) + ext2(p_ii_ff);
      s3_ni_ff     <= ext2(p_ir_ff) - ext2(p_ri_ff);
      s3_den_ff    <= $unsigned(p_bb_ff) + $unsigned(p_cc_ff);
   end

   // stage 4: divider setup, then one quotient bit per stage
   dv_type dv_ff [0:DW];
   dv_type dv0_in;
   dv_type dv_in [1:DW];

   // valid bits are cleared here so each stage register takes one assignment
   always_comb begin
      dv0_in.valid  = s3_valid_ff & ~reset;
      dv0_in.is_div = s3_is_div_ff;
      dv0_in.dz     = s3_den_ff == '0;
      dv0_in.den    = s3_den_ff;
      dv0_in.p_re   = part_init(s3_nr_ff, s3_den_ff);
      dv0_in.p_im   = part_init(s3_ni_ff, s3_den_ff);
      dv0_in.res    = s3_res_ff;
   end

   always_comb begin
      for (int k = 1; k <= DW; k++) begin
         dv_in[k]       = dv_ff[k-1];
         dv_in[k].valid = dv_ff[k-1].valid & ~reset;
         dv_in[k].p_re  = part_step(dv_ff[k-1].p_re, dv_ff[k-1].den);
         dv_in[k].p_im  = part_step(dv_ff[k-1].p_im, dv_ff[k-1].den);
      end
   end

   always_ff @(posedge clock) begin
      dv_ff[0] <= dv0_in;
      for (int k = 1; k <= DW; k++) begin
         dv_ff[k] <= dv_in[k];
      end
   end

   // output stage
   logic [DW:0] fin_re, fin_im;
   res_type     out_in;

   always_comb begin
      fin_re = part_final(dv_ff[DW].p_re);
      fin_im = part_final(dv_ff[DW].p_im);
      if (!dv_ff[DW].is_div) begin
         out_in = dv_ff[DW].res;
      end else if (dv_ff[DW].dz) begin
         out_in.re     = '0;
         out_in.im     = '0;
         out_in.cmp    = 1'b0;
         out_in.status = ST_DIVZ;
      end else begin
         out_in.re     = fin_re[DW-1:0];
         out_in.im     = fin_im[DW-1:0];
         out_in.cmp    = 1'b0;
         out_in.status = (fin_re[DW] || fin_im[DW]) ? ST_SAT : ST_OK;
      end
   end

   logic    rsp_valid_ff;
   res_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_ff[DW].valid;
      end
      rsp_ff <= out_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_res_re       = rsp_ff.re;
   assign rsp_res_im       = rsp_ff.im;
   assign rsp_compare_true = rsp_ff.cmp;
   assign rsp_status       = rsp_ff.status;

`ifndef SYNTHESIS
   a_last_stage_delivers: assert property (@(posedge clock) disable iff (reset)
      dv_ff[DW].valid |=> rsp_valid)
      else $error("finished item not delivered");

   a_compare_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_true |->
         rsp_res_re == '0 && rsp_res_im == '0 && rsp_status == ST_OK)
      else $error("compare result carries data or status");

   a_divz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DIVZ |-> rsp_res_re == '0 && rsp_res_im == '0)
      else $error("divide by zero returned nonzero data");

   a_entry_to_divider: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |=> dv_ff[0].valid)
      else $error("item lost before divider");
`endif

endmodule
`default_nettype wire

// ----- sim/cau_checker.sv -----
// Checker for the complex arithmetic unit: watches both channels, predicts results, compares.
`timescale 1ns / 1ps
module cau_checker import cau_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 busy,
   input  wire logic [3:0]           req_op,
   input  wire logic signed [DW-1:0] req_a_re,
   input  wire logic signed [DW-1:0] req_a_im,
   input  wire logic signed [DW-1:0] req_b_re,
   input  wire logic signed [DW-1:0] req_b_im,
   input  wire logic                 rsp_valid,
   input  wire logic signed [DW-1:0] rsp_res_re,
   input  wire logic signed [DW-1:0] rsp_res_im,
   input  wire logic                 rsp_compare_true,
   input  wire logic [1:0]           rsp_status,
   output int                        errors,
   output int                        pending
);

   typedef struct {
      logic signed [DW-1:0] re;
      logic signed [DW-1:0] im;
      logic                 cmp;
      logic [1:0]           status;
   } cplx_res_type;

   cplx_res_type answer_q[$];
   int           mismatches;

   localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

   // clamp a wide exact value to the data range
   function automatic logic signed [DW-1:0] clamp(input logic signed [199:0] v,
                                                  inout logic sat);
      if (v > $signed({{(200-DW){1'b0}}, MAXV})) begin
         sat = 1'b1;
         return MAXV;
      end
      if (v < $signed({{(200-DW){1'b1}}, MINV})) begin
         sat = 1'b1;
         return MINV;
      end
      return v[DW-1:0];
   endfunction

   // floor shift of an exact product sum
   function automatic logic signed [199:0] floor_frac(input logic signed [199:0] v);
      return v >>> FW;
   endfunction

   // numerator * 2^FW / den, truncated toward zero
   function automatic logic signed [199:0] quot(input logic signed [199:0] n,
                                                input logic signed [199:0] d);
      logic signed [199:0] mag;
      logic signed [199:0] q;
      mag = n < 0 ? -n : n;
      q = (mag <<< FW) / d;
      return n < 0 ? -q : q;
   endfunction

   function automatic cplx_res_type predict_alu(input logic [3:0] op,
         input logic signed [DW-1:0] ar, input logic signed [DW-1:0] ai,
         input logic signed [DW-1:0] br, input logic signed [DW-1:0] bi);
      cplx_res_type r;
      logic signed [199:0] xr, xi, wr, wi, vr, vi, den, one;
      logic sat;
      logic arith;
      wr = ar; wi = ai; vr = br; vi = bi;
      one = 200'sd1 <<< FW;
      xr = 0; xi = 0; sat = 1'b0; arith = 1'b1;
      r.re = '0; r.im = '0; r.cmp = 1'b0; r.status = ST_OK;
      case (op)
         OP_ADD: begin xr = wr + vr; xi = wi + vi; end
         OP_SUB: begin xr = wr - vr; xi = wi - vi; end
         OP_MUL: begin
            xr = floor_frac(wr * vr - wi * vi);
            xi = floor_frac(wr * vi + wi * vr);
         end
         OP_DIV: begin
            den = vr * vr + vi * vi;
            if (den == 0) begin
               arith = 1'b0;
               r.status = ST_DIVZ;
            end else begin
               xr = quot(wr * vr + wi * vi, den);
               xi = quot(wi * vr - wr * vi, den);
            end
         end
         OP_NEG: begin xr = -wr; xi = -wi; end
         OP_PASS: begin xr = wr; xi = wi; end
         OP_EQ, OP_NE: begin
            arith = 1'b0;
            r.cmp = ((op == OP_EQ) == (ar == br && ai == bi));
         end
         OP_INC: begin xr = wr + one; xi = wi + one; end
         OP_DEC: begin xr = wr - one; xi = wi - one; end
         default: arith = 1'b0;
      endcase
      if (arith) begin
         r.re = clamp(xr, sat);
         r.im = clamp(xi, sat);
         r.status = sat ? ST_SAT : ST_OK;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      cplx_res_type exp_r;
      if (reset) begin
         answer_q.delete();
         errors <= 0;
         mismatches = 0;
      end else begin
         if (rsp_valid) begin
            if (answer_q.size() == 0) begin
               errors <= errors + 1;
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result transfer re=%h im=%h", rsp_res_re, rsp_res_im);
            end else begin
               exp_r = answer_q.pop_front();
               if (rsp_res_re !== exp_r.re || rsp_res_im !== exp_r.im ||
                   rsp_compare_true !== exp_r.cmp || rsp_status !== exp_r.status) begin
                  errors <= errors + 1;
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: exp re=%h im=%h cmp=%0d st=%0d",
                               " got re=%h im=%h cmp=%0d st=%0d"},
                              exp_r.re, exp_r.im, exp_r.cmp, exp_r.status,
                              rsp_res_re, rsp_res_im, rsp_compare_true, rsp_status);
               end
            end
         end
         if (start && !busy)
            answer_q.push_back(predict_alu(req_op, req_a_re, req_a_im, req_b_re, req_b_im));
      end
      pending = answer_q.size();
   end

endmodule

// ----- sim/testbench.sv -----
// Testbench top: stimulus for the complex arithmetic unit and the final verdict.
`timescale 1ns / 1ps
module testbench;
   import cau_pkg::*;

   logic                 clock, reset, start;
   logic                 busy;
   logic [3:0]           req_op;
   logic signed [DW-1:0] req_a_re, req_a_im, req_b_re, req_b_im;
   logic                 rsp_valid, rsp_compare_true;
   logic signed [DW-1:0] rsp_res_re, rsp_res_im;
   logic [1:0]           rsp_status;
   int                   errors, pending, idle_cycles;

   localparam int LATENCY = DW + 5;
   localparam int WATCHDOG = 2000;
   localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [DW-1:0] ONE = 1 <<< FW;

   complex_arithmetic_unit dut (.*);
   cau_checker check (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   function automatic logic signed [DW-1:0] rand_val();
      case ($urandom_range(0, 7))
         0: return MAXV;
         1: return MINV;
         2: return '0;
         3: return $signed($urandom_range(0, 8)) <<< FW;
         4: return -($signed($urandom_range(0, 8)) <<< FW);
         5: return $signed($urandom_range(0, 131071)) - 65536;
         default: return $urandom;
      endcase
   endfunction

   // one item, held until accepted; gap decides an idle cycle first
   task automatic send(input logic [3:0] op, input logic signed [DW-1:0] ar,
                       input logic signed [DW-1:0] ai, input logic signed [DW-1:0] br,
                       input logic signed [DW-1:0] bi, input bit gap);
      if (gap) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_op <= op; req_a_re <= ar; req_a_im <= ai; req_b_re <= br; req_b_im <= bi;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic signed [DW-1:0] x, y;
      int w;
      reset = 1'b1; start = 1'b0; req_op = '0;
      req_a_re = '0; req_a_im = '0; req_b_re = '0; req_b_im = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // directed: extremes, every op, overflow, zero divisor, compares, unused codes
      send(OP_ADD, MAXV, MINV, MAXV, MINV, 0);
      send(OP_SUB, MINV, MAXV, MAXV, MINV, 0);
      send(OP_MUL, MINV, MINV, MINV, MINV, 0);
      send(OP_MUL, -ONE, ONE, 3, -5, 0);
      send(OP_DIV, ONE, ONE, 0, 0, 0);
      send(OP_DIV, MAXV, MINV, 1, 0, 0);
      send(OP_DIV, ONE, -ONE, 3, 7, 0);
      send(OP_DIV, MINV, MINV, MINV, MINV, 0);
      send(OP_NEG, MINV, MAXV, 0, 0, 0);
      send(OP_PASS, MAXV, MINV, '1, '1, 0);
      send(OP_EQ, MAXV, MINV, MAXV, MINV, 0);
      send(OP_EQ, MAXV, MINV, MAXV, 0, 0);
      send(OP_NE, 5, 6, 5, 6, 0);
      send(OP_NE, 5, 6, 5, 7, 0);
      send(OP_INC, MAXV, 0, 0, 0, 0);
      send(OP_DEC, MINV, 0, 0, 0, 0);
      send(4'd10, 1, 2, 3, 4, 0);
      send(4'd15, '1, '1, '1, '1, 0);
      // pause until the pipeline drains
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      for (int i = 0; i < 1550; i++) begin
         x = rand_val();
         y = rand_val();
         w = $urandom_range(0, 15);
         send(4'(w < 12 ? w % 10 : w), rand_val(), rand_val(),
              ($urandom_range(0, 9) == 0) ? 0 : x,
              ($urandom_range(0, 9) == 0) ? 0 : y,
              (i % 500 >= 400) ? 1'b0 : ($urandom_range(0, 99) < 27));
      end
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
